[rtl/tsup_pkg.sv]
// Shared types, constants and tick conversion helpers for the tick supervisor.
package tsup_pkg;

  localparam int TICKS_PER_SECOND = 100;

  // Register widths as the registers are specified
  localparam int IVAL_SEC_W  = 12;
  localparam int TMO_SEC_W   = 6;
  localparam int LED_OFF_W   = 9;
  localparam int LED_ON_W    = 6;
  localparam int LIMIT_SEC_W = 10;

  localparam int NUM_TASKS = 3;
  localparam int TASK_W    = 2;
  localparam int WATCH_W   = 16;

  // Largest value the send counter can reach: interval plus timeout, both at full scale
  localparam int SEND_CNT_MAX = ((1 << IVAL_SEC_W) - 1 + (1 << TMO_SEC_W) - 1) * TICKS_PER_SECOND;
  localparam int SEND_W       = $clog2(SEND_CNT_MAX + 2);
  localparam int LIMIT_W      = $clog2(((1 << LIMIT_SEC_W) - 1) * TICKS_PER_SECOND + 1);
  localparam int CMP_W        = (LIMIT_W > WATCH_W) ? LIMIT_W : WATCH_W;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SEND_ACK = 2'd1,
    CMD_ARM      = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    UPD_STOPPED  = 2'd0,
    UPD_STARTING = 2'd1,
    UPD_RUNNING  = 2'd2
  } upd_e;

  typedef enum logic [2:0] {
    REG_REPORT_INTERVAL = 3'd0,
    REG_RESEND_TIMEOUT  = 3'd1,
    REG_LED_OFF         = 3'd2,
    REG_LED_ON          = 3'd3,
    REG_RADIO_LIMIT     = 3'd4,
    REG_SENSOR_LIMIT    = 3'd5,
    REG_UPDATE_LIMIT    = 3'd6
  } reg_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [TASK_W-1:0] task_index;
    logic [1:0]        update_state;
  } in_item_t;

  typedef struct packed {
    logic led_level;
    logic watchdog_kick;
    logic send_request;
    logic resume_update;
    logic system_reset;
  } out_item_t;

  // Tick-domain view of the configuration, handed from the register file to the core
  typedef struct packed {
    logic [LED_OFF_W-1:0]                 led_off;
    logic [LED_ON_W-1:0]                  led_on;
    logic [SEND_W-1:0]                    ival_ticks;
    logic [SEND_W-1:0]                    tmo_ticks;
    logic [SEND_W-1:0]                    reload_ticks;
    logic [NUM_TASKS-1:0][LIMIT_W-1:0]    limit_ticks;
  } cfg_t;

  function automatic logic [SEND_W-1:0] send_ticks(input logic [IVAL_SEC_W:0] secs);
    return SEND_W'(secs) * SEND_W'(TICKS_PER_SECOND);
  endfunction

  function automatic logic [LIMIT_W-1:0] limit_ticks(input logic [LIMIT_SEC_W-1:0] secs);
    return LIMIT_W'(secs) * LIMIT_W'(TICKS_PER_SECOND);
  endfunction

  // Reload after a resend timeout: one tick short of the interval, floored at zero
  function automatic logic [SEND_W-1:0] reload_of(input logic [SEND_W-1:0] ival);
    return (ival == '0) ? '0 : ival - SEND_W'(1);
  endfunction

endpackage

[rtl/tsup_cfg_regs.sv]
// APB register file; keeps raw settings and their tick-converted forms.
module tsup_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsup_pkg::ADDR_W-1:0] paddr,
  input  logic [tsup_pkg::DATA_W-1:0] pwdata,
  output logic [tsup_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output tsup_pkg::cfg_t              cfg_o
);

  logic [tsup_pkg::IVAL_SEC_W-1:0]  ival_sec_q;
  logic [tsup_pkg::TMO_SEC_W-1:0]   tmo_sec_q;
  logic [tsup_pkg::LED_OFF_W-1:0]   led_off_q;
  logic [tsup_pkg::LED_ON_W-1:0]    led_on_q;
  logic [tsup_pkg::NUM_TASKS-1:0][tsup_pkg::LIMIT_SEC_W-1:0] limit_sec_q;
  tsup_pkg::cfg_t                   cfg_q;

  logic                             wr_en;
  tsup_pkg::reg_e                   wr_idx;
  logic [tsup_pkg::IVAL_SEC_W-1:0]  new_ival;
  logic [tsup_pkg::TMO_SEC_W-1:0]   new_tmo;
  logic [tsup_pkg::SEND_W-1:0]      new_ival_ticks;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = tsup_pkg::reg_e'(paddr[tsup_pkg::ADDR_W-1:2]);

  assign new_ival       = pwdata[tsup_pkg::IVAL_SEC_W-1:0];
  assign new_tmo        = pwdata[tsup_pkg::TMO_SEC_W-1:0];
  assign new_ival_ticks = tsup_pkg::send_ticks({1'b0, new_ival});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ival_sec_q     <= tsup_pkg::IVAL_SEC_W'(60);
      tmo_sec_q      <= tsup_pkg::TMO_SEC_W'(10);
      led_off_q      <= tsup_pkg::LED_OFF_W'(300);
      led_on_q       <= tsup_pkg::LED_ON_W'(3);
      limit_sec_q[0] <= tsup_pkg::LIMIT_SEC_W'(90);
      limit_sec_q[1] <= tsup_pkg::LIMIT_SEC_W'(90);
      limit_sec_q[2] <= tsup_pkg::LIMIT_SEC_W'(300);
      cfg_q.led_off        <= tsup_pkg::LED_OFF_W'(300);
      cfg_q.led_on         <= tsup_pkg::LED_ON_W'(3);
      cfg_q.ival_ticks     <= tsup_pkg::send_ticks(13'd60);
      cfg_q.tmo_ticks      <= tsup_pkg::send_ticks(13'd70);
      cfg_q.reload_ticks   <= tsup_pkg::reload_of(tsup_pkg::send_ticks(13'd60));
      cfg_q.limit_ticks[0] <= tsup_pkg::limit_ticks(tsup_pkg::LIMIT_SEC_W'(90));
      cfg_q.limit_ticks[1] <= tsup_pkg::limit_ticks(tsup_pkg::LIMIT_SEC_W'(90));
      cfg_q.limit_ticks[2] <= tsup_pkg::limit_ticks(tsup_pkg::LIMIT_SEC_W'(300));
    end else if (wr_en) begin
      unique case (wr_idx)
        tsup_pkg::REG_REPORT_INTERVAL: begin
          ival_sec_q         <= new_ival;
          cfg_q.ival_ticks   <= new_ival_ticks;
          cfg_q.reload_ticks <= tsup_pkg::reload_of(new_ival_ticks);
          cfg_q.tmo_ticks    <= tsup_pkg::send_ticks({1'b0, new_ival} +
                                                     {7'b0, tmo_sec_q});
        end
        tsup_pkg::REG_RESEND_TIMEOUT: begin
          tmo_sec_q       <= new_tmo;
          cfg_q.tmo_ticks <= tsup_pkg::send_ticks({1'b0, ival_sec_q} + {7'b0, new_tmo});
        end
        tsup_pkg::REG_LED_OFF: begin
          led_off_q     <= pwdata[tsup_pkg::LED_OFF_W-1:0];
          cfg_q.led_off <= pwdata[tsup_pkg::LED_OFF_W-1:0];
        end
        tsup_pkg::REG_LED_ON: begin
          led_on_q     <= pwdata[tsup_pkg::LED_ON_W-1:0];
          cfg_q.led_on <= pwdata[tsup_pkg::LED_ON_W-1:0];
        end
        tsup_pkg::REG_RADIO_LIMIT: begin
          limit_sec_q[0]       <= pwdata[tsup_pkg::LIMIT_SEC_W-1:0];
          cfg_q.limit_ticks[0] <= tsup_pkg::limit_ticks(pwdata[tsup_pkg::LIMIT_SEC_W-1:0]);
        end
        tsup_pkg::REG_SENSOR_LIMIT: begin
          limit_sec_q[1]       <= pwdata[tsup_pkg::LIMIT_SEC_W-1:0];
          cfg_q.limit_ticks[1] <= tsup_pkg::limit_ticks(pwdata[tsup_pkg::LIMIT_SEC_W-1:0]);
        end
        tsup_pkg::REG_UPDATE_LIMIT: begin
          limit_sec_q[2]       <= pwdata[tsup_pkg::LIMIT_SEC_W-1:0];
          cfg_q.limit_ticks[2] <= tsup_pkg::limit_ticks(pwdata[tsup_pkg::LIMIT_SEC_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (wr_idx)
      tsup_pkg::REG_REPORT_INTERVAL: prdata = tsup_pkg::DATA_W'(ival_sec_q);
      tsup_pkg::REG_RESEND_TIMEOUT:  prdata = tsup_pkg::DATA_W'(tmo_sec_q);
      tsup_pkg::REG_LED_OFF:         prdata = tsup_pkg::DATA_W'(led_off_q);
      tsup_pkg::REG_LED_ON:          prdata = tsup_pkg::DATA_W'(led_on_q);
      tsup_pkg::REG_RADIO_LIMIT:     prdata = tsup_pkg::DATA_W'(limit_sec_q[0]);
      tsup_pkg::REG_SENSOR_LIMIT:    prdata = tsup_pkg::DATA_W'(limit_sec_q[1]);
      tsup_pkg::REG_UPDATE_LIMIT:    prdata = tsup_pkg::DATA_W'(limit_sec_q[2]);
      default:                       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/tsup_core.sv]
// Supervisor state, per-command update logic and the result register.
module tsup_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsup_pkg::cfg_t      cfg_i,
  input  logic                item_valid_i,
  input  tsup_pkg::in_item_t  item_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tsup_pkg::out_item_t out_item_o
);

  logic [tsup_pkg::LED_OFF_W-1:0] led_cnt_q, led_cnt_d;
  logic                           led_line_q, led_line_d;
  logic [tsup_pkg::SEND_W-1:0]    send_cnt_q, send_cnt_d;
  logic [tsup_pkg::NUM_TASKS-1:0][tsup_pkg::WATCH_W-1:0] watch_q, watch_d;
  logic                           out_valid_q, out_valid_d;
  tsup_pkg::out_item_t            out_item_q, out_item_d;

  logic                           take;
  logic [tsup_pkg::LED_OFF_W:0]   led_next;
  logic [tsup_pkg::LED_OFF_W:0]   led_on_end;
  logic [tsup_pkg::SEND_W-1:0]    send_inc;
  logic [tsup_pkg::NUM_TASKS-1:0][tsup_pkg::WATCH_W-1:0] watch_inc;
  logic [tsup_pkg::NUM_TASKS-1:0] trip;

  // Take a beat when the result slot is empty or drains this cycle
  assign take   = item_valid_i && (!out_valid_q || !out_stall_i);
  assign take_o = take;

  assign led_next   = {1'b0, led_cnt_q} + 1'b1;
  assign led_on_end = {1'b0, cfg_i.led_off} + (tsup_pkg::LED_OFF_W + 1)'(cfg_i.led_on);
  assign send_inc   = send_cnt_q + 1'b1;

  always_comb begin
    for (int i = 0; i < tsup_pkg::NUM_TASKS; i++) begin
      watch_inc[i] = (watch_q[i] == '1) ? watch_q[i] : watch_q[i] + 1'b1;
      trip[i]      = (watch_q[i] != '0) &&
                     (tsup_pkg::CMP_W'(watch_inc[i]) >= tsup_pkg::CMP_W'(cfg_i.limit_ticks[i]));
    end
  end

  always_comb begin
    led_cnt_d  = led_cnt_q;
    led_line_d = led_line_q;
    send_cnt_d = send_cnt_q;
    watch_d    = watch_q;
    out_item_d = out_item_q;
    if (take) begin
      out_item_d = '0;
      unique case (tsup_pkg::cmd_e'(item_i.command))
        tsup_pkg::CMD_TICK: begin
          // LED pattern: high phase, low phase, then wrap and kick
          if (led_cnt_q != '1 && led_next <= {1'b0, cfg_i.led_off}) begin
            led_line_d = 1'b1;
            led_cnt_d  = led_next[tsup_pkg::LED_OFF_W-1:0];
          end else if (led_cnt_q != '1 && led_next <= led_on_end) begin
            led_line_d = 1'b0;
            led_cnt_d  = led_next[tsup_pkg::LED_OFF_W-1:0];
          end else begin
            led_cnt_d                = '0;
            out_item_d.watchdog_kick = 1'b1;
          end
          if (item_i.update_state == tsup_pkg::UPD_STOPPED) begin
            if (send_inc == cfg_i.ival_ticks) begin
              send_cnt_d              = send_inc;
              out_item_d.send_request = 1'b1;
            end else if (send_inc >= cfg_i.tmo_ticks) begin
              send_cnt_d = cfg_i.reload_ticks;
            end else begin
              send_cnt_d = send_inc;
            end
          end else if (item_i.update_state == tsup_pkg::UPD_STARTING) begin
            out_item_d.resume_update = 1'b1;
          end
          for (int i = 0; i < tsup_pkg::NUM_TASKS; i++) begin
            if (watch_q[i] != '0) begin
              watch_d[i] = watch_inc[i];
            end
          end
          out_item_d.system_reset = |trip;
        end
        tsup_pkg::CMD_SEND_ACK: begin
          send_cnt_d = '0;
        end
        tsup_pkg::CMD_ARM: begin
          if (item_i.task_index < tsup_pkg::TASK_W'(tsup_pkg::NUM_TASKS)) begin
            watch_d[item_i.task_index] = tsup_pkg::WATCH_W'(1);
          end
        end
        tsup_pkg::CMD_CLEAR: begin
          if (item_i.task_index < tsup_pkg::TASK_W'(tsup_pkg::NUM_TASKS)) begin
            watch_d[item_i.task_index] = '0;
          end
        end
        default: begin
        end
      endcase
      out_item_d.led_level = led_line_d;
    end
  end

  always_comb begin
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_cnt_q   <= '0;
      led_line_q  <= 1'b0;
      send_cnt_q  <= '0;
      watch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      led_cnt_q   <= led_cnt_d;
      led_line_q  <= led_line_d;
      send_cnt_q  <= send_cnt_d;
      watch_q     <= watch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  a_send_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_cnt_q <= tsup_pkg::SEND_W'(tsup_pkg::SEND_CNT_MAX))
    else $error("send counter beyond its ceiling");

  a_kick_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && out_item_d.watchdog_kick |=> led_cnt_q == '0)
    else $error("watchdog kick without LED counter wrap");

  a_send_resume_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_item_q.send_request && out_item_q.resume_update))
    else $error("send request and resume pulse in one result");

  a_nontick_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && item_i.command != tsup_pkg::CMD_TICK |=>
      out_valid_q && !out_item_q.watchdog_kick && !out_item_q.send_request &&
      !out_item_q.resume_update && !out_item_q.system_reset)
    else $error("pulse raised on a non-tick command");

  a_led_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && item_i.command != tsup_pkg::CMD_TICK |=> $stable(led_cnt_q) && $stable(led_line_q))
    else $error("LED state moved on a non-tick command");
`endif

endmodule

[rtl/tick_supervisor_timers.sv]
// Top level of the tick supervisor: input register, register file and core.
// Path: an accepted beat passes the input register, then the result register that
//   the state update writes.
// Throughput: one beat per cycle, back to back, while the result channel is not stalled.
// A stalled result holds the result register; the input register keeps taking a beat
//   whenever it drains in the same cycle.
// Reset (rst_ni, async low): counters and LED line cleared, all task watches unarmed,
//   registers back to their defaults; both valid flags drop.
module tick_supervisor_timers (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsup_pkg::ADDR_W-1:0] paddr,
  input  logic [tsup_pkg::DATA_W-1:0] pwdata,
  output logic [tsup_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // Command channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tsup_pkg::in_item_t          in_item_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tsup_pkg::out_item_t         out_item_o
);

  tsup_pkg::cfg_t     cfg;
  logic               in_valid_q, in_valid_d;
  tsup_pkg::in_item_t in_item_q;
  logic               in_accept;
  logic               core_take;

  // Hold the stage full until the core takes it; a drained stage refills at once
  assign in_stall_o = in_valid_q && !core_take;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (core_take) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload needs no reset; load only on an accepted beat
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
  end

  tsup_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsup_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (in_valid_q),
    .item_i       (in_item_q),
    .take_o       (core_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

[tb/tick_supervisor_timers_tb.sv]
// Self-checking testbench for the tick supervisor: table-driven and random beats under a predictor.
`timescale 1ns / 1ps

module tick_supervisor_timers_tb;

  // Run control
  localparam int CYCLE_LIMIT  = 1_000_000;  // watchdog ceiling on the whole run
  localparam int DRAIN_CYCLES = 6;          // margin after the last expected result
  localparam int BURST_TICKS  = 40;         // back-to-back ticks with every watch armed

  // Predictor ceilings
  localparam int LED_CNT_CEIL = 511;
  localparam int WATCH_CEIL   = 65535;

  // Task selectors and the odd codes the fields still allow
  localparam logic [1:0] TASK_RADIO  = 2'd0;
  localparam logic [1:0] TASK_SENSOR = 2'd1;
  localparam logic [1:0] TASK_UPDATE = 2'd2;
  localparam logic [1:0] TASK_NONE   = 2'd3;
  localparam logic [1:0] UPD_ODD     = 2'd3;
  localparam logic [2:0] REG_SPARE   = 3'd7;

  // Results that read straight off the state after reset
  localparam tsup_pkg::out_item_t RES_LED_HIGH   = 5'b10000;
  localparam tsup_pkg::out_item_t RES_LED_RESUME = 5'b10010;

  typedef struct {
    tsup_pkg::in_item_t  beat;
    bit                  known;  // result typed in below instead of taken from the predictor
    tsup_pkg::out_item_t res;
  } row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [tsup_pkg::ADDR_W-1:0] paddr;
  logic [tsup_pkg::DATA_W-1:0] pwdata;
  logic [tsup_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  logic                        in_valid_i;
  logic                        in_stall_o;
  tsup_pkg::in_item_t          in_item_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  tsup_pkg::out_item_t         out_item_o;

  // Predictor copy of the configuration and state
  int        cfg_val [8];
  int        led_cnt;
  bit        led_lvl;
  int        send_cnt;
  int        watch_cnt [tsup_pkg::NUM_TASKS];

  tsup_pkg::out_item_t pending_status [$];
  tsup_pkg::out_item_t want_status;
  row_t                plan [$];

  int errors;
  int beats;
  int cycles;
  int settings;
  int n_kick;
  int n_send;
  int n_resume;
  int n_reset;
  bit quiet;       // suppress idling on both sides
  int stall_left;

  tick_supervisor_timers DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Append one row to the directed table.
  function automatic void add_row(logic [1:0] cmd, logic [1:0] idx, logic [1:0] ust, bit known,
                                  tsup_pkg::out_item_t res);
    row_t r;
    r.beat  = tsup_pkg::in_item_t'({cmd, idx, ust});
    r.known = known;
    r.res   = res;
    plan.push_back(r);
  endfunction

  // Apply one command to the predicted supervisor state and return its status beat.
  function automatic tsup_pkg::out_item_t advance_supervisor(tsup_pkg::in_item_t b);
    tsup_pkg::out_item_t r;
    int                  nxt;
    int                  ival;
    int                  tmo;
    int                  lim;
    r = '0;
    case (b.command)
      tsup_pkg::CMD_TICK: begin
        // LED pattern: high phase, low phase, then wrap with a watchdog kick
        nxt = led_cnt + 1;
        if (nxt <= cfg_val[tsup_pkg::REG_LED_OFF] && nxt <= LED_CNT_CEIL) begin
          led_lvl = 1'b1;
          led_cnt = nxt;
        end else if (nxt <= cfg_val[tsup_pkg::REG_LED_OFF] + cfg_val[tsup_pkg::REG_LED_ON] &&
                     nxt <= LED_CNT_CEIL) begin
          led_lvl = 1'b0;
          led_cnt = nxt;
        end else begin
          led_cnt = 0;
          r.watchdog_kick = 1'b1;
        end
        // Report timer runs only while updates are stopped
        if (b.update_state == tsup_pkg::UPD_STOPPED) begin
          ival = cfg_val[tsup_pkg::REG_REPORT_INTERVAL] * tsup_pkg::TICKS_PER_SECOND;
          tmo  = (cfg_val[tsup_pkg::REG_REPORT_INTERVAL] +
                  cfg_val[tsup_pkg::REG_RESEND_TIMEOUT]) * tsup_pkg::TICKS_PER_SECOND;
          send_cnt++;
          if (send_cnt == ival) begin
            r.send_request = 1'b1;
          end else if (send_cnt >= tmo) begin
            send_cnt = (ival > 0) ? ival - 1 : 0;
          end
        end else if (b.update_state == tsup_pkg::UPD_STARTING) begin
          r.resume_update = 1'b1;
        end
        // Liveness watches: zero means unarmed, armed ones saturate
        for (int t = 0; t < tsup_pkg::NUM_TASKS; t++) begin
          lim = cfg_val[tsup_pkg::REG_RADIO_LIMIT + t] * tsup_pkg::TICKS_PER_SECOND;
          if (watch_cnt[t] != 0) begin
            if (watch_cnt[t] < WATCH_CEIL) watch_cnt[t]++;
            if (watch_cnt[t] >= lim) r.system_reset = 1'b1;
          end
        end
      end
      tsup_pkg::CMD_SEND_ACK: send_cnt = 0;
      tsup_pkg::CMD_ARM: if (b.task_index < tsup_pkg::NUM_TASKS) watch_cnt[b.task_index] = 1;
      default: if (b.task_index < tsup_pkg::NUM_TASKS) watch_cnt[b.task_index] = 0;
    endcase
    r.led_level = led_lvl;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none while quiet.
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic got, logic want);
    if (got !== want) flag_mismatch($sformatf("%s got %b want %b", name, got, want));
  endtask

  // Write one register, then read it back; the spare index is written but never read.
  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    logic [31:0] masked;
    case (idx)
      tsup_pkg::REG_REPORT_INTERVAL: masked = value & ((32'd1 << tsup_pkg::IVAL_SEC_W) - 1);
      tsup_pkg::REG_RESEND_TIMEOUT:  masked = value & ((32'd1 << tsup_pkg::TMO_SEC_W) - 1);
      tsup_pkg::REG_LED_OFF:         masked = value & ((32'd1 << tsup_pkg::LED_OFF_W) - 1);
      tsup_pkg::REG_LED_ON:          masked = value & ((32'd1 << tsup_pkg::LED_ON_W) - 1);
      tsup_pkg::REG_RADIO_LIMIT,
      tsup_pkg::REG_SENSOR_LIMIT,
      tsup_pkg::REG_UPDATE_LIMIT:    masked = value & ((32'd1 << tsup_pkg::LIMIT_SEC_W) - 1);
      default:                       masked = '0;
    endcase
    // Setup, then access; the write lands at the access edge with pready high
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx > tsup_pkg::REG_UPDATE_LIMIT) return;
    cfg_val[idx] = masked;
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== masked)
      flag_mismatch($sformatf("register %0d read %0h want %0h", idx, prdata, masked));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_settings(int ri, int rt, int lo, int ln, int rl, int sl, int ul);
    cfg_write(tsup_pkg::REG_REPORT_INTERVAL, ri);
    cfg_write(tsup_pkg::REG_RESEND_TIMEOUT, rt);
    cfg_write(tsup_pkg::REG_LED_OFF, lo);
    cfg_write(tsup_pkg::REG_LED_ON, ln);
    cfg_write(tsup_pkg::REG_RADIO_LIMIT, rl);
    cfg_write(tsup_pkg::REG_SENSOR_LIMIT, sl);
    cfg_write(tsup_pkg::REG_UPDATE_LIMIT, ul);
    settings++;
  endtask

  // Present one command beat, hold it until accepted, then queue what it should produce.
  task automatic drive_beat(tsup_pkg::in_item_t b, bit known, tsup_pkg::out_item_t typed);
    int                  gap;
    tsup_pkg::out_item_t pred;
    gap = idle_len();
    if (gap != 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = advance_supervisor(b);
    pending_status.push_back(known ? typed : pred);
    beats++;
  endtask

  // Mostly ticks; acks kept rare so the report timer gets far enough to fire.
  task automatic run_random(int n, int ack_pct);
    tsup_pkg::in_item_t b;
    int                 r;
    int                 u;
    logic [1:0]         ust;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) quiet = ($urandom_range(4) == 0);
      r = $urandom_range(99);
      u = $urandom_range(9);
      if (u < 6)       ust = tsup_pkg::UPD_STOPPED;
      else if (u == 6) ust = tsup_pkg::UPD_STARTING;
      else if (u < 9)  ust = tsup_pkg::UPD_RUNNING;
      else             ust = UPD_ODD;
      if (r < ack_pct)           b.command = tsup_pkg::CMD_SEND_ACK;
      else if (r < ack_pct + 8)  b.command = tsup_pkg::CMD_ARM;
      else if (r < ack_pct + 12) b.command = tsup_pkg::CMD_CLEAR;
      else                       b.command = tsup_pkg::CMD_TICK;
      b.task_index   = 2'($urandom_range(3));
      b.update_state = ust;
      drive_beat(b, 1'b0, '0);
    end
    quiet = 1'b0;
  endtask

  // Drop valid, wait out every queued result, then let the pipeline settle.
  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: randomly stall, changing only on the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = idle_len();
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Checker: compare every accepted status beat against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        flag_mismatch("status beat with nothing expected");
      end else begin
        want_status = pending_status.pop_front();
        check_field("led_level", out_item_o.led_level, want_status.led_level);
        check_field("watchdog_kick", out_item_o.watchdog_kick, want_status.watchdog_kick);
        check_field("send_request", out_item_o.send_request, want_status.send_request);
        check_field("resume_update", out_item_o.resume_update, want_status.resume_update);
        check_field("system_reset", out_item_o.system_reset, want_status.system_reset);
      end
      n_kick   += out_item_o.watchdog_kick;
      n_send   += out_item_o.send_request;
      n_resume += out_item_o.resume_update;
      n_reset  += out_item_o.system_reset;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_status.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    // Hold every input at a known value from time zero
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    quiet       = 1'b0;
    stall_left  = 0;
    errors      = 0;
    beats       = 0;
    cycles      = 0;
    settings    = 1;
    n_kick      = 0;
    n_send      = 0;
    n_resume    = 0;
    n_reset     = 0;

    // Register defaults and cleared state, as after reset
    cfg_val[tsup_pkg::REG_REPORT_INTERVAL] = 60;
    cfg_val[tsup_pkg::REG_RESEND_TIMEOUT]  = 10;
    cfg_val[tsup_pkg::REG_LED_OFF]         = 300;
    cfg_val[tsup_pkg::REG_LED_ON]          = 3;
    cfg_val[tsup_pkg::REG_RADIO_LIMIT]     = 90;
    cfg_val[tsup_pkg::REG_SENSOR_LIMIT]    = 90;
    cfg_val[tsup_pkg::REG_UPDATE_LIMIT]    = 300;
    led_cnt  = 0;
    led_lvl  = 1'b0;
    send_cnt = 0;
    foreach (watch_cnt[t]) watch_cnt[t] = 0;

    // Directed table at the reset settings: every command, every task slot
    // including the unused one, every update state including the odd one.
    // Early in the LED high phase with far-off limits, most results are plain.
    add_row(tsup_pkg::CMD_TICK, TASK_RADIO, tsup_pkg::UPD_STOPPED, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_TICK, TASK_RADIO, tsup_pkg::UPD_STARTING, 1'b1, RES_LED_RESUME);
    add_row(tsup_pkg::CMD_TICK, TASK_RADIO, tsup_pkg::UPD_RUNNING, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_TICK, TASK_RADIO, UPD_ODD, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_SEND_ACK, TASK_RADIO, tsup_pkg::UPD_STOPPED, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_ARM, TASK_RADIO, tsup_pkg::UPD_STOPPED, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_ARM, TASK_SENSOR, tsup_pkg::UPD_STOPPED, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_ARM, TASK_UPDATE, tsup_pkg::UPD_STOPPED, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_ARM, TASK_NONE, tsup_pkg::UPD_STOPPED, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_TICK, TASK_RADIO, tsup_pkg::UPD_STOPPED, 1'b0, '0);
    add_row(tsup_pkg::CMD_TICK, TASK_RADIO, tsup_pkg::UPD_STARTING, 1'b0, '0);
    add_row(tsup_pkg::CMD_ARM, TASK_RADIO, tsup_pkg::UPD_RUNNING, 1'b0, '0);
    add_row(tsup_pkg::CMD_CLEAR, TASK_NONE, tsup_pkg::UPD_STOPPED, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_CLEAR, TASK_RADIO, tsup_pkg::UPD_STOPPED, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_TICK, TASK_RADIO, tsup_pkg::UPD_RUNNING, 1'b0, '0);
    add_row(tsup_pkg::CMD_CLEAR, TASK_SENSOR, tsup_pkg::UPD_STOPPED, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_CLEAR, TASK_UPDATE, tsup_pkg::UPD_STOPPED, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_TICK, TASK_NONE, UPD_ODD, 1'b0, '0);
    add_row(tsup_pkg::CMD_CLEAR, TASK_NONE, UPD_ODD, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_SEND_ACK, TASK_NONE, UPD_ODD, 1'b1, RES_LED_HIGH);
    add_row(tsup_pkg::CMD_TICK, TASK_NONE, tsup_pkg::UPD_STARTING, 1'b1, RES_LED_RESUME);

    // Reset once, released on a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (plan[k]) drive_beat(plan[k].beat, plan[k].known, plan[k].res);
    run_random(100, 2);
    drain();

    // Smallest legal settings: short LED cycle, one-second timers and limits.
    // Also poke the spare address, which must change nothing.
    load_settings(1, 1, 1, 1, 1, 1, 1);
    cfg_write(REG_SPARE, '1);
    run_random(150, 1);
    drain();

    // Largest legal settings
    load_settings(3600, 60, 400, 50, 600, 600, 600);
    run_random(60, 2);
    drain();

    // All zero: kick every tick, no report ever, any armed watch trips at once
    load_settings(0, 0, 0, 0, 0, 0, 0);
    run_random(60, 2);
    drain();

    // Full register width from all-ones writes: widest LED cycle and limits above
    // the watch ceiling. Arm every watch and tick back to back without idling.
    load_settings(-1, -1, -1, -1, -1, -1, -1);
    quiet = 1'b1;
    drive_beat(tsup_pkg::in_item_t'({tsup_pkg::CMD_ARM, TASK_RADIO, tsup_pkg::UPD_STOPPED}),
               1'b0, '0);
    drive_beat(tsup_pkg::in_item_t'({tsup_pkg::CMD_ARM, TASK_SENSOR, tsup_pkg::UPD_STOPPED}),
               1'b0, '0);
    drive_beat(tsup_pkg::in_item_t'({tsup_pkg::CMD_ARM, TASK_UPDATE, tsup_pkg::UPD_STOPPED}),
               1'b0, '0);
    repeat (BURST_TICKS)
      drive_beat(tsup_pkg::in_item_t'({tsup_pkg::CMD_TICK, 2'($urandom_range(3)),
                                       2'($urandom_range(3))}),
                 1'b0, '0);
    quiet = 1'b0;
    run_random(40, 2);
    drain();

    // Small random settings, zeros included, so reports and trips come often
    repeat (3) begin
      load_settings($urandom_range(2), $urandom_range(2), $urandom_range(12),
                    $urandom_range(6), $urandom_range(3), $urandom_range(3),
                    $urandom_range(3));
      run_random(80, 1);
      drain();
    end

    $display("ran %0d command beats across %0d register settings in %0d cycles",
             beats, settings, cycles);
    $display("status seen: %0d kicks, %0d send requests, %0d resumes, %0d reset flags",
             n_kick, n_send, n_resume, n_reset);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, pending_status.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tsup_pkg.sv
rtl/tsup_cfg_regs.sv
rtl/tsup_core.sv
rtl/tick_supervisor_timers.sv
tb/tick_supervisor_timers_tb.sv
